// ===== src/ifs_pkg.sv =====
// Shared types, constants and arithmetic helpers for the IFS chaos-game plotter.
package ifs_pkg;

    localparam int COEF_VALUE_W = 32;
    localparam int RAND_W       = 16;
    localparam int COEFS_AFFINE = 6;   // a..f per map
    localparam logic [2:0] COEF_PROB = 3'd6;

    // operation codes on the input stream
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MAP_COUNT   = 3'd0;
    localparam logic [2:0] CFG_CENTER_X    = 3'd1;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [2:0] CFG_COS_SPIN    = 3'd3;
    localparam logic [2:0] CFG_SIN_SPIN    = 3'd4;
    localparam logic [2:0] CFG_VIEW_SCALE  = 3'd5;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd7;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_STEP,
        CMD_RESTART
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [1:0]         map_idx;
        logic [2:0]         coef_idx;
        logic signed [31:0] value;
        logic [15:0]        rnd;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         map_count;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [17:0] cos_spin;
        logic signed [17:0] sin_spin;
        logic [30:0]        view_scale;
        logic [10:0]        grid_width;
        logic [10:0]        grid_height;
    } t_cfg;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_OUT
    } t_bstate;

    // product / 65536, truncated toward zero
    function automatic logic signed [47:0] qdiv_prod(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return adj[63:16];
    endfunction

    // 49-bit offset / 65536 truncated toward zero, saturated to 16 bits
    function automatic logic signed [15:0] proj_sat(input logic signed [48:0] v);
        logic signed [48:0] adj;
        logic signed [32:0] q;
        adj = v + (v[48] ? 49'sd65535 : 49'sd0);
        q   = adj[48:16];
        if (q > 33'sd32767) begin
            return 16'sh7fff;
        end else if (q < -33'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

endpackage

// ===== src/ifs_chaos_game_plotter.sv =====
// Top level of the IFS chaos-game plotter: ports, configuration registers, output stage.
// Step request path: queue, map pick, 16 sequencer phases on one shared 32x32 multiplier,
//   output load; a step is finished before the back end takes the next request.
// Load and restart requests are handled in the back end's idle state and give no result.
// Input requests are taken while the two-entry queue has room; the output register
//   frees the back end as soon as a waiting result is taken.
// Synchronous active-low reset restores the configuration, clears the orbit point and
//   warm-up count; the coefficient table is undefined until loaded.
module ifs_chaos_game_plotter #(
    parameter int MAX_MAPS     = 4,
    parameter int WARMUP_STEPS = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // map_index[1:0], coef_index[4:2], coef_value[36:5], random_value[52:37], zero fill
    input  logic [55:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // point_x[31:0], point_y[63:32], screen_x[79:64], screen_y[95:80],
    // chosen_map[97:96], on_screen[98], plot_valid[99], zero fill
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ifs_pkg::*;

    t_cfg r_cfg;

    logic   w_push, w_pop, w_full, w_empty;
    t_cmd   w_front_cmd, w_queue_cmd;
    logic   w_out_load;
    logic   w_out_free;
    logic [103:0] w_out_data;

    logic         r_out_valid;
    logic [103:0] r_out_data;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_count   <= 3'd1;
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.cos_spin    <= 18'sd65536;
            r_cfg.sin_spin    <= '0;
            r_cfg.view_scale  <= 31'd65536;
            r_cfg.grid_width  <= 11'd256;
            r_cfg.grid_height <= 11'd128;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_COUNT:   r_cfg.map_count   <= i_cfg_data[2:0];
                CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                CFG_COS_SPIN:    r_cfg.cos_spin    <= i_cfg_data[17:0];
                CFG_SIN_SPIN:    r_cfg.sin_spin    <= i_cfg_data[17:0];
                CFG_VIEW_SCALE:  r_cfg.view_scale  <= i_cfg_data[30:0];
                CFG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_data[10:0];
                CFG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    ifs_front #(
        .MAX_MAPS (MAX_MAPS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd),
        .i_full        (w_full)
    );

    ifs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_queue_cmd)
    );

    ifs_back #(
        .MAX_MAPS     (MAX_MAPS),
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_cmd      (w_queue_cmd),
        .o_pop      (w_pop),
        .o_out_load (w_out_load),
        .o_out_data (w_out_data),
        .i_out_free (w_out_free)
    );

    // output register: slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== src/ifs_front.sv =====
// Front end: takes input requests, drops ignored ones and classifies the rest.
module ifs_front #(
    parameter int MAX_MAPS = 4
) (
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [55:0]      s_axis_tdata,
    input  logic [1:0]       s_axis_tuser,
    output logic             o_push,
    output ifs_pkg::t_cmd    o_cmd,
    input  logic             i_full
);
    import ifs_pkg::*;

    logic [1:0]  w_op;
    logic [1:0]  w_map;
    logic [2:0]  w_coef;
    logic        w_keep;
    logic [4:0]  w_map_ext;

    assign w_op      = s_axis_tuser;
    assign w_map     = s_axis_tdata[1:0];
    assign w_coef    = s_axis_tdata[4:2];
    assign w_map_ext = {3'b000, w_map};

    // requests with no effect are consumed here and never queued
    always_comb begin
        w_keep         = 1'b0;
        o_cmd.kind     = CMD_STEP;
        o_cmd.map_idx  = w_map;
        o_cmd.coef_idx = w_coef;
        o_cmd.value    = s_axis_tdata[36:5];
        o_cmd.rnd      = s_axis_tdata[52:37];
        case (w_op)
            OP_LOAD: begin
                o_cmd.kind = CMD_LOAD;
                w_keep     = (w_map_ext < 5'(MAX_MAPS)) && (w_coef <= COEF_PROB);
            end
            OP_STEP: begin
                o_cmd.kind = CMD_STEP;
                w_keep     = 1'b1;
            end
            OP_RESTART: begin
                o_cmd.kind = CMD_RESTART;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep     = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full && w_keep;

endmodule

// ===== src/ifs_queue.sv =====
// Two-entry request queue between front end and back end.
module ifs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ifs_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ifs_pkg::t_cmd  o_cmd
);
    import ifs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== src/ifs_back.sv =====
// Back end: map table, orbit state and the shared-multiplier step sequencer.
module ifs_back #(
    parameter int MAX_MAPS     = 4,
    parameter int WARMUP_STEPS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ifs_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  ifs_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_out_load,
    output logic [103:0]   o_out_data,
    input  logic           i_out_free
);
    import ifs_pkg::*;

    localparam int MI_W  = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int N_W   = $clog2(MAX_MAPS + 1) + 1;
    localparam int DEPTH = MAX_MAPS * COEFS_AFFINE;
    localparam int CA_W  = $clog2(DEPTH);

    // coefficient memory a..f, probabilities in flops (compared in parallel)
    logic signed [31:0] r_coef [DEPTH];
    logic signed [31:0] r_prob [MAX_MAPS];
    logic signed [31:0] r_rdata;

    t_bstate r_state, n_state;
    logic [3:0]  r_ph, n_ph;

    logic signed [31:0] r_ox, r_oy;
    logic [4:0]         r_warm;
    logic [MI_W-1:0]    r_map;
    logic [CA_W-1:0]    r_base;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_t, r_u, r_nx, r_ny, r_rx, r_ry, r_wx, r_wy;
    logic signed [48:0] r_vx, r_vy;
    logic signed [15:0] r_sx, r_sy;

    logic signed [31:0] w_opa, w_opb;
    logic signed [63:0] w_mul;
    logic signed [47:0] w_qw;
    logic signed [31:0] w_q;
    logic [MI_W-1:0]    w_pick;
    logic [N_W-1:0]     w_n;
    logic [CA_W-1:0]    w_raddr;
    logic [CA_W-1:0]    w_waddr;
    logic signed [16:0] w_rnd;
    logic               w_on;
    logic               w_warm;
    logic signed [48:0] w_gx, w_gy;

    // map choice: first map in use with random <= p, else the last in use
    always_comb begin
        w_n = N_W'(i_cfg.map_count);
        if (w_n == '0) begin
            w_n = N_W'(1);
        end else if (w_n > N_W'(MAX_MAPS)) begin
            w_n = N_W'(MAX_MAPS);
        end
        w_rnd  = $signed({1'b0, i_cmd.rnd});
        w_pick = MI_W'(w_n - N_W'(1));
        for (int i = MAX_MAPS - 1; i >= 0; i--) begin
            if ((N_W'(i) < w_n) && (32'(w_rnd) <= r_prob[i])) begin
                w_pick = MI_W'(i);
            end
        end
    end

    assign w_raddr = r_base + CA_W'(r_ph);
    assign w_waddr = CA_W'(CA_W'(i_cmd.map_idx) * CA_W'(COEFS_AFFINE))
                   + CA_W'(i_cmd.coef_idx);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == CMD_LOAD) begin
            if (i_cmd.coef_idx == COEF_PROB) begin
                r_prob[MI_W'(i_cmd.map_idx)] <= i_cmd.value;
            end else begin
                r_coef[w_waddr] <= i_cmd.value;
            end
        end
        r_rdata <= r_coef[w_raddr];
    end

    // shared multiplier operand selection
    always_comb begin
        w_opa = r_rdata;
        w_opb = r_ox;
        case (r_ph)
            4'd1:  begin w_opa = r_rdata; w_opb = r_ox; end
            4'd2:  begin w_opa = r_rdata; w_opb = r_oy; end
            4'd3:  begin w_opa = r_rdata; w_opb = r_ox; end
            4'd4:  begin w_opa = r_rdata; w_opb = r_oy; end
            4'd7:  begin w_opa = r_rx; w_opb = 32'(i_cfg.cos_spin); end
            4'd8:  begin w_opa = r_ry; w_opb = 32'(i_cfg.sin_spin); end
            4'd9:  begin w_opa = r_rx; w_opb = 32'(i_cfg.sin_spin); end
            4'd10: begin w_opa = r_ry; w_opb = 32'(i_cfg.cos_spin); end
            4'd11: begin w_opa = r_wx; w_opb = $signed({1'b0, i_cfg.view_scale}); end
            4'd12: begin w_opa = r_wy; w_opb = $signed({1'b0, i_cfg.view_scale}); end
            default: begin w_opa = r_rdata; w_opb = r_ox; end
        endcase
    end

    assign w_mul = w_opa * w_opb;
    assign w_qw  = qdiv_prod(r_prod);
    assign w_q   = w_qw[31:0];
    assign w_gx  = $signed({23'd0, i_cfg.grid_width, 15'd0});
    assign w_gy  = $signed({23'd0, i_cfg.grid_height, 15'd0});

    always_ff @(posedge i_clk) begin
        if (r_state == B_CALC) begin
            r_prod <= w_mul;
            case (r_ph)
                4'd2:  r_t  <= w_q;
                4'd3:  r_t  <= r_t + w_q;
                4'd4:  r_u  <= w_q;
                4'd5:  begin r_nx <= r_t + r_rdata; r_u <= r_u + w_q; end
                4'd6:  begin r_ny <= r_u + r_rdata; r_rx <= r_nx - i_cfg.center_x; end
                4'd7:  r_ry <= r_ny - i_cfg.center_y;
                4'd8:  r_t  <= w_q;
                4'd9:  r_wx <= r_t - w_q;
                4'd10: r_t  <= w_q;
                4'd11: r_wy <= r_t + w_q;
                4'd12: r_vx <= w_gx + 49'(w_qw);
                4'd13: r_vy <= w_gy - 49'(w_qw);
                4'd14: r_sx <= proj_sat(r_vx);
                4'd15: r_sy <= proj_sat(r_vy);
                default: ;
            endcase
        end
        if (o_pop && i_cmd.kind == CMD_STEP) begin
            r_map  <= w_pick;
            r_base <= CA_W'(CA_W'(w_pick) * CA_W'(COEFS_AFFINE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ph    <= 4'd0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_warm  <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            if (o_pop && i_cmd.kind == CMD_RESTART) begin
                r_ox   <= '0;
                r_oy   <= '0;
                r_warm <= '0;
            end else if (o_out_load) begin
                r_ox <= r_nx;
                r_oy <= r_ny;
                if (!w_warm) begin
                    r_warm <= r_warm + 5'd1;
                end
            end
        end
    end

    assign w_warm = (r_warm >= 5'(WARMUP_STEPS));
    assign w_on   = !r_sx[15] && (r_sx[14:0] < {4'd0, i_cfg.grid_width}) &&
                    !r_sy[15] && (r_sy[14:0] < {4'd0, i_cfg.grid_height});

    always_comb begin
        n_state    = r_state;
        n_ph       = r_ph;
        o_pop      = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            B_IDLE: begin
                n_ph = 4'd0;
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_STEP) begin
                        n_state = B_CALC;
                    end
                end
            end
            B_CALC: begin
                n_ph = r_ph + 4'd1;
                if (r_ph == 4'd15) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // point_x, point_y, screen_x, screen_y, chosen_map, on_screen, plot_valid
    assign o_out_data = {4'd0, w_on && w_warm, w_on, 2'(r_map), r_sy, r_sx, r_ny, r_nx};

endmodule
